// File: design/aipt_pkg.sv
// Shared types, constants and helper functions of the affine inverse point transform.
package aipt_pkg;

	localparam int DATA_W    = 32;
	localparam int MEM_DEPTH = 12;
	localparam int MEM_AW    = 4;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_XFORM = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_POINT  = 1'b1;

	localparam logic [1:0] ROW_TRANS = 2'd3;

	typedef struct packed {
		logic               command;
		logic [1:0]         row_index;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
	} cmd_t;

	typedef struct packed {
		logic               result_kind;
		logic               singular;
		logic signed [31:0] out_forward;
		logic signed [31:0] out_right;
		logic signed [31:0] out_up;
	} res_t;

	// Matrix entries of one cofactor: p*q - r*s.
	typedef struct packed {
		logic [MEM_AW-1:0] p;
		logic [MEM_AW-1:0] q;
		logic [MEM_AW-1:0] r;
		logic [MEM_AW-1:0] s;
	} cof_sel_t;

	function automatic cof_sel_t cof_sel(input logic [3:0] idx);
		cof_sel_t c;
		unique case (idx)
			4'd0:    c = '{4'd4, 4'd8, 4'd5, 4'd7};
			4'd1:    c = '{4'd2, 4'd7, 4'd1, 4'd8};
			4'd2:    c = '{4'd1, 4'd5, 4'd2, 4'd4};
			4'd3:    c = '{4'd5, 4'd6, 4'd3, 4'd8};
			4'd4:    c = '{4'd0, 4'd8, 4'd2, 4'd6};
			4'd5:    c = '{4'd2, 4'd3, 4'd0, 4'd5};
			4'd6:    c = '{4'd3, 4'd7, 4'd4, 4'd6};
			4'd7:    c = '{4'd1, 4'd6, 4'd0, 4'd7};
			4'd8:    c = '{4'd0, 4'd4, 4'd1, 4'd3};
			default: c = '{4'd0, 4'd0, 4'd0, 4'd0};
		endcase
		return c;
	endfunction

	// Clamp a wide signed value to the signed 32 bit range.
	function automatic logic [31:0] sat32(input logic signed [66:0] v);
		logic [31:0] r;
		if (v[66:31] == {36{v[66]}}) begin
			r = v[31:0];
		end else if (v[66]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

// File: design/affine_inverse_point_transform.sv
// Top level: sequencer, shared multiplier and state memories of the point transform.
//
// Usage: a request is taken on the rising edge where start is high and busy low.
// cmd.command 0 loads matrix row cmd.row_index (rows 0..2 are the 3x3 part, row 3
// the translation). Rows 0..2 give no result. Loading row 3 inverts the matrix
// and gives one status result (result_kind 0, singular flag) after it stores the
// row, computes the determinant, runs nine cofactor divides at one quotient bit
// per cycle and computes the translation; a zero determinant skips the divides.
// cmd.command 1 transforms a point; the single 33x33 multiplier does four products
// for each of three components, with operands read one per cycle from the inverse
// memory. While the stored matrix is singular a transform answers in the next
// cycle with zeros.
// Each result is on result for one cycle with done high; it cannot be held off.
// cfg_we writes cfg_data to the vertical lift at any edge; write it while idle.
// Reset clears the lift, marks the inverse as singular and returns to idle.
// Matrix rows must all be loaded before the first row 3 load.
module affine_inverse_point_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  aipt_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done,
	output aipt_pkg::res_t      result,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_COF, ST_DET, ST_CHK, ST_DIVS, ST_DIVW, ST_DOT, ST_FIN
	} state_t;

	state_t                        state_q;
	logic [2:0]                    step_q;
	logic [3:0]                    idx_q;
	logic [1:0]                    col_q;
	logic                          div_ph_q;
	logic                          xform_q;
	logic                          singular_q;
	logic signed [31:0]            lift_q;
	aipt_pkg::res_t                res_q;
	logic                          done_q;

	aipt_pkg::cmd_t                in_q;
	logic signed [31:0]            opa_q;
	logic signed [65:0]            prod_q;
	logic signed [64:0]            cof_q;
	logic signed [99:0]            det_q;
	logic signed [66:0]            acc_q;
	logic signed [31:0]            comp_q [3];

	logic                          m_we;
	logic [aipt_pkg::MEM_AW-1:0]   m_wa;
	logic [31:0]                   m_wd;
	logic [aipt_pkg::MEM_AW-1:0]   m_ra;
	logic [31:0]                   m_rd;
	logic                          i_we;
	logic [aipt_pkg::MEM_AW-1:0]   i_wa;
	logic [31:0]                   i_wd;
	logic [aipt_pkg::MEM_AW-1:0]   i_ra;
	logic [31:0]                   i_rd;

	logic signed [32:0]            mul_a;
	logic signed [32:0]            mul_b;
	aipt_pkg::cof_sel_t            cs;
	logic [1:0]                    term;
	logic [3:0]                    det_col;
	logic signed [66:0]            acc_neg;
	logic signed [66:0]            up_sum;
	logic                          div_start;
	logic                          div_done;
	logic [31:0]                   div_q;
	logic                          accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	aipt_ram #(.Width(aipt_pkg::DATA_W), .Depth(aipt_pkg::MEM_DEPTH)) u_matrix (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_wa),
		.wdata (m_wd),
		.raddr (m_ra),
		.rdata (m_rd)
	);

	aipt_ram #(.Width(aipt_pkg::DATA_W), .Depth(aipt_pkg::MEM_DEPTH)) u_inverse (
		.clk   (clk),
		.we    (i_we),
		.waddr (i_wa),
		.wdata (i_wd),
		.raddr (i_ra),
		.rdata (i_rd)
	);

	assign div_start = (state_q == ST_DIVS);

	aipt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.cof      (cof_q),
		.det      (det_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		cs      = aipt_pkg::cof_sel(idx_q);
		term    = 2'(step_q - 3'd1);
		det_col = (idx_q == 4'd0) ? 4'd0 : ((idx_q == 4'd3) ? 4'd1 : 4'd2);
		acc_neg = -acc_q;
		up_sum  = {{35{comp_q[2][31]}}, comp_q[2]} + {{35{lift_q[31]}}, lift_q};
		m_we  = 1'b0;
		m_wa  = '0;
		m_wd  = '0;
		m_ra  = '0;
		i_we  = 1'b0;
		i_wa  = '0;
		i_wd  = '0;
		i_ra  = '0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LOAD: begin
				m_we = 1'b1;
				m_wa = 4'({2'b0, in_q.row_index} * 4'd3) + 4'(step_q);
				case (step_q)
					3'd0:    m_wd = in_q.value_x;
					3'd1:    m_wd = in_q.value_y;
					default: m_wd = in_q.value_z;
				endcase
			end
			ST_COF: begin
				case (step_q)
					3'd0: m_ra = cs.p;
					3'd1: m_ra = cs.q;
					3'd2: begin
						m_ra  = cs.r;
						mul_a = {opa_q[31], opa_q};
						mul_b = {m_rd[31], m_rd};
					end
					3'd3: m_ra = cs.s;
					3'd4: begin
						mul_a = {opa_q[31], opa_q};
						mul_b = {m_rd[31], m_rd};
					end
					default: ;
				endcase
			end
			ST_DET: begin
				case (step_q)
					3'd0: m_ra = det_col;
					3'd1: begin
						mul_a = {m_rd[31], m_rd};
						mul_b = {1'b0, cof_q[31:0]};
					end
					3'd2: begin
						mul_a = {opa_q[31], opa_q};
						mul_b = cof_q[64:32];
					end
					default: ;
				endcase
			end
			ST_DIVW: begin
				i_we = div_done;
				i_wa = idx_q;
				i_wd = div_q;
			end
			ST_DOT: begin
				i_ra = 4'({1'b0, step_q} * 4'd3) + {2'b0, col_q};
				if (step_q < 3'd3) begin
					m_ra = 4'd9 + 4'(step_q);
				end
				if (step_q >= 3'd1 && step_q <= 3'd4) begin
					if (xform_q) begin
						case (term)
							2'd0: begin
								mul_a = {in_q.value_x[31], in_q.value_x};
								mul_b = {i_rd[31], i_rd};
							end
							2'd1: begin
								mul_a = {in_q.value_y[31], in_q.value_y};
								mul_b = {i_rd[31], i_rd};
							end
							2'd2: begin
								mul_a = {in_q.value_z[31], in_q.value_z};
								mul_b = {i_rd[31], i_rd};
							end
							default: begin
								// Translation term scaled by 2^16.
								mul_a = {i_rd[31], i_rd};
								mul_b = 33'sh10000;
							end
						endcase
					end else if (term != 2'd3) begin
						mul_a = {m_rd[31], m_rd};
						mul_b = {i_rd[31], i_rd};
					end
				end
				if (step_q == 3'd6 && !xform_q) begin
					i_we = 1'b1;
					i_wa = 4'd9 + {2'b0, col_q};
					i_wd = aipt_pkg::sat32(acc_neg >>> 16);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			idx_q      <= '0;
			col_q      <= '0;
			div_ph_q   <= 1'b0;
			xform_q    <= 1'b0;
			singular_q <= 1'b1;
			lift_q     <= '0;
			res_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				lift_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q <= '0;
						if (cmd.command == aipt_pkg::CMD_LOAD) begin
							state_q <= ST_LOAD;
						end else if (singular_q) begin
							done_q <= 1'b1;
							res_q  <= '{aipt_pkg::KIND_POINT, 1'b1, 32'sd0, 32'sd0, 32'sd0};
						end else begin
							state_q <= ST_DOT;
							xform_q <= 1'b1;
							col_q   <= '0;
						end
					end
				end
				ST_LOAD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						step_q   <= '0;
						idx_q    <= '0;
						div_ph_q <= 1'b0;
						state_q  <= (in_q.row_index == aipt_pkg::ROW_TRANS) ? ST_COF : ST_IDLE;
					end
				end
				ST_COF: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						step_q  <= '0;
						state_q <= div_ph_q ? ST_DIVS : ST_DET;
					end
				end
				ST_DET: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						step_q <= '0;
						if (idx_q == 4'd6) begin
							state_q <= ST_CHK;
						end else begin
							idx_q   <= idx_q + 4'd3;
							state_q <= ST_COF;
						end
					end
				end
				ST_CHK: begin
					if (det_q == '0) begin
						// The old inverse stays in memory but is no longer used.
						singular_q <= 1'b1;
						done_q     <= 1'b1;
						res_q      <= '{aipt_pkg::KIND_STATUS, 1'b1, 32'sd0, 32'sd0, 32'sd0};
						state_q    <= ST_IDLE;
					end else begin
						idx_q    <= '0;
						div_ph_q <= 1'b1;
						state_q  <= ST_COF;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						if (idx_q == 4'd8) begin
							state_q <= ST_DOT;
							xform_q <= 1'b0;
							col_q   <= '0;
							step_q  <= '0;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= ST_COF;
						end
					end
				end
				ST_DOT: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						step_q <= '0;
						if (col_q == 2'd2) begin
							if (xform_q) begin
								state_q <= ST_FIN;
							end else begin
								singular_q <= 1'b0;
								done_q     <= 1'b1;
								res_q      <= '{aipt_pkg::KIND_STATUS, 1'b0,
									32'sd0, 32'sd0, 32'sd0};
								state_q    <= ST_IDLE;
							end
						end else begin
							col_q <= col_q + 2'd1;
						end
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					res_q.result_kind <= aipt_pkg::KIND_POINT;
					res_q.singular    <= 1'b0;
					res_q.out_forward <= comp_q[1];
					res_q.out_right   <= (comp_q[0] == 32'sh8000_0000) ? 32'sh7FFF_FFFF
						: -comp_q[0];
					res_q.out_up      <= aipt_pkg::sat32(up_sum);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			in_q <= cmd;
		end
		case (state_q)
			ST_LOAD: det_q <= '0;
			ST_COF: begin
				if (step_q == 3'd1) begin
					opa_q <= m_rd;
				end else if (step_q == 3'd3) begin
					cof_q <= prod_q[64:0];
					opa_q <= m_rd;
				end else if (step_q == 3'd5) begin
					cof_q <= cof_q - $signed(prod_q[64:0]);
				end
			end
			ST_DET: begin
				if (step_q == 3'd1) begin
					opa_q <= m_rd;
				end else if (step_q == 3'd2) begin
					det_q <= det_q + {{34{prod_q[65]}}, prod_q};
				end else if (step_q == 3'd3) begin
					det_q <= det_q + {{2{prod_q[65]}}, prod_q, 32'h0};
				end
			end
			ST_DOT: begin
				if (step_q == 3'd2) begin
					acc_q <= {prod_q[65], prod_q};
				end else if (step_q >= 3'd3 && step_q <= 3'd5) begin
					acc_q <= acc_q + {prod_q[65], prod_q};
				end else if (step_q == 3'd6 && xform_q) begin
					comp_q[col_q] <= aipt_pkg::sat32(acc_q >>> 16);
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result issued while the sequencer is working");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.result_kind == aipt_pkg::KIND_STATUS |->
			res_q.out_forward == '0 && res_q.out_right == '0 && res_q.out_up == '0)
		else $error("status result carries nonzero position");
	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider finished outside the wait state");
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.command == aipt_pkg::CMD_LOAD |=> busy)
		else $error("row load request did not start the sequencer");
`endif

endmodule

// File: design/aipt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module aipt_ram #(
	parameter int Width = 32,
	parameter int Depth = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/aipt_div.sv
// Bit-serial restoring divider giving trunc(cof * 2^32 / det) saturated to 32 bits.
module aipt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [64:0] cof,
	input  logic signed [99:0] det,
	output logic               done,
	output logic [31:0]        quotient
);

	localparam int NumBits = 96;

	logic [97:0]  rem_q;
	logic [95:0]  num_q;
	logic [97:0]  den_q;
	logic         neg_q;
	logic [6:0]   cnt_q;
	logic         run_q;
	logic [64:0]  cof_mag;
	logic [99:0]  det_mag;
	logic [97:0]  r2;
	logic [98:0]  diff;
	logic         ge;
	logic         q_ovf_pos;
	logic         q_ovf_neg;

	always_comb begin
		cof_mag = cof[64] ? 65'(-cof) : 65'(cof);
		det_mag = det[99] ? 100'(-det) : 100'(det);
		r2 = {rem_q[96:0], num_q[95]};
		diff = {1'b0, r2} - {1'b0, den_q};
		ge = !diff[98];
		q_ovf_pos = |num_q[95:31];
		q_ovf_neg = (|num_q[95:32]) || (num_q[31] && (|num_q[30:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'(NumBits);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= {cof_mag[63:0], 32'h0};
			den_q <= det_mag[97:0];
			neg_q <= cof[64] ^ det[99];
		end else if (run_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? diff[97:0] : r2;
				num_q <= {num_q[94:0], ge};
			end else if (neg_q) begin
				quotient <= q_ovf_neg ? 32'h8000_0000 : 32'(-num_q[31:0]);
			end else begin
				quotient <= q_ovf_pos ? 32'h7FFF_FFFF : num_q[31:0];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !run_q)
		else $error("divider done while still running");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q) && $past(cnt_q) == '0)
		else $error("divider done without finishing all steps");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("divider restarted while running");
`endif

endmodule

// File: tb/sv/aipt_checker.sv
// Checker of the point transform: predicts every result from the requests and compares.
module aipt_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  aipt_pkg::cmd_t   cmd,
	input  logic             busy,
	input  logic             done,
	input  aipt_pkg::res_t   result,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_data,
	output int               errors,
	output int               pending
);

	logic signed [31:0] matrix_q[12];
	logic signed [31:0] inverse_q[12];
	logic               no_inverse;
	logic signed [31:0] lift_q;
	aipt_pkg::res_t     expected_q[$];

	function automatic logic signed [159:0] widen(input logic signed [31:0] v);
		return v;
	endfunction

	function automatic logic signed [31:0] clamp(input logic signed [159:0] v);
		if (v > 160'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -160'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Adjugate inversion; a zero determinant leaves the old inverse in place.
	task automatic invert_matrix();
		logic signed [159:0] cof[9];
		logic signed [159:0] det;
		logic signed [159:0] acc;
		cof[0] = widen(matrix_q[4]) * widen(matrix_q[8]) - widen(matrix_q[5]) * widen(matrix_q[7]);
		cof[3] = widen(matrix_q[5]) * widen(matrix_q[6]) - widen(matrix_q[3]) * widen(matrix_q[8]);
		cof[6] = widen(matrix_q[3]) * widen(matrix_q[7]) - widen(matrix_q[4]) * widen(matrix_q[6]);
		cof[1] = widen(matrix_q[2]) * widen(matrix_q[7]) - widen(matrix_q[1]) * widen(matrix_q[8]);
		cof[4] = widen(matrix_q[0]) * widen(matrix_q[8]) - widen(matrix_q[2]) * widen(matrix_q[6]);
		cof[7] = widen(matrix_q[1]) * widen(matrix_q[6]) - widen(matrix_q[0]) * widen(matrix_q[7]);
		cof[2] = widen(matrix_q[1]) * widen(matrix_q[5]) - widen(matrix_q[2]) * widen(matrix_q[4]);
		cof[5] = widen(matrix_q[2]) * widen(matrix_q[3]) - widen(matrix_q[0]) * widen(matrix_q[5]);
		cof[8] = widen(matrix_q[0]) * widen(matrix_q[4]) - widen(matrix_q[1]) * widen(matrix_q[3]);
		det = widen(matrix_q[0]) * cof[0] + widen(matrix_q[1]) * cof[3]
			+ widen(matrix_q[2]) * cof[6];
		if (det == 0) begin
			no_inverse = 1'b1;
			return;
		end
		for (int j = 0; j < 9; j++) begin
			inverse_q[j] = clamp((cof[j] <<< 32) / det);
		end
		for (int j = 0; j < 3; j++) begin
			acc = widen(matrix_q[9]) * widen(inverse_q[j])
				+ widen(matrix_q[10]) * widen(inverse_q[3 + j])
				+ widen(matrix_q[11]) * widen(inverse_q[6 + j]);
			inverse_q[9 + j] = clamp((-acc) >>> 16);
		end
		no_inverse = 1'b0;
	endtask

	function automatic aipt_pkg::res_t transform_point(input aipt_pkg::cmd_t c);
		aipt_pkg::res_t      r;
		logic signed [159:0] acc;
		logic signed [31:0]  comp[3];
		r = '0;
		r.result_kind = aipt_pkg::KIND_POINT;
		r.singular    = no_inverse;
		if (!no_inverse) begin
			for (int j = 0; j < 3; j++) begin
				acc = widen(c.value_x) * widen(inverse_q[j])
					+ widen(c.value_y) * widen(inverse_q[3 + j])
					+ widen(c.value_z) * widen(inverse_q[6 + j])
					+ widen(inverse_q[9 + j]) * 160'sd65536;
				comp[j] = clamp(acc >>> 16);
			end
			r.out_forward = comp[1];
			r.out_right   = clamp(-widen(comp[0]));
			r.out_up      = clamp(widen(comp[2]) + widen(lift_q));
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		aipt_pkg::res_t want;
		int             row;
		if (!arst_n) begin
			for (int j = 0; j < 12; j++) begin
				matrix_q[j]  = '0;
				inverse_q[j] = '0;
			end
			no_inverse = 1'b1;
			lift_q     = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report("unexpected result kind", result.result_kind, 'x);
				end else begin
					want = expected_q.pop_front();
					if (result.result_kind !== want.result_kind)
						report("result_kind", result.result_kind, want.result_kind);
					if (result.singular !== want.singular)
						report("singular", result.singular, want.singular);
					if (result.out_forward !== want.out_forward)
						report("out_forward", result.out_forward, want.out_forward);
					if (result.out_right !== want.out_right)
						report("out_right", result.out_right, want.out_right);
					if (result.out_up !== want.out_up)
						report("out_up", result.out_up, want.out_up);
				end
			end
			if (cfg_we) lift_q = cfg_data;
			if (start && !busy) begin
				if (cmd.command == aipt_pkg::CMD_LOAD) begin
					row = cmd.row_index;
					matrix_q[row * 3]     = cmd.value_x;
					matrix_q[row * 3 + 1] = cmd.value_y;
					matrix_q[row * 3 + 2] = cmd.value_z;
					if (cmd.row_index == aipt_pkg::ROW_TRANS) begin
						invert_matrix();
						want = '0;
						want.result_kind = aipt_pkg::KIND_STATUS;
						want.singular    = no_inverse;
						expected_q.push_back(want);
					end
				end else begin
					expected_q.push_back(transform_point(cmd));
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

// File: tb/sv/tb_affine_inverse_point_transform.sv
// Testbench top: clock, reset, request stimulus, lift writes and the verdict.
module tb_affine_inverse_point_transform;

	localparam int ONE       = 65536;
	localparam int CYCLE_CAP = 2000000;

	logic           clk;
	logic           arst_n;
	logic           start;
	aipt_pkg::cmd_t cmd;
	logic           busy;
	logic           done;
	aipt_pkg::res_t result;
	logic           cfg_we;
	logic [31:0]    cfg_data;
	int             errors;
	int             pending;
	int             cycles;
	bit             calm;

	affine_inverse_point_transform i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	aipt_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("tb_affine_inverse_point_transform: FAIL");
			$finish;
		end
	end

	// Mix of full-range words, small integers, small fractions, the two extremes and values near the unit scale.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 4))
			0:       return $urandom();
			1:       return (int'($urandom_range(0, 8)) - 4) * ONE;
			2:       return int'($urandom_range(0, 1 << 19)) - (1 << 18);
			3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return ONE + int'($urandom_range(0, 4095)) - 2048;
		endcase
	endfunction

	task automatic send(input logic c, input logic [1:0] row,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		cmd.command   <= c;
		cmd.row_index <= row;
		cmd.value_x   <= x;
		cmd.value_y   <= y;
		cmd.value_z   <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drops start and lets the last request be counted, then waits until the block is idle
	// and every request has been answered.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic write_lift(input logic [31:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic load_matrix(input logic [31:0] m[12]);
		for (int r = 0; r < 4; r++) begin
			send(aipt_pkg::CMD_LOAD, r[1:0], m[r * 3], m[r * 3 + 1], m[r * 3 + 2]);
		end
	endtask

	initial begin
		logic [31:0] m[12];
		int          n;
		int          points;
		start    = 1'b0;
		cmd      = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Transform before any inverse exists answers with the singular flag.
		send(aipt_pkg::CMD_XFORM, 2'd0, ONE, -ONE, 32'h7FFF_FFFF);
		// Identity with translation, then points at the field extremes.
		m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 3 * ONE, -2 * ONE, ONE / 2};
		load_matrix(m);
		send(aipt_pkg::CMD_XFORM, 2'd3, 0, 0, 0);
		send(aipt_pkg::CMD_XFORM, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(aipt_pkg::CMD_XFORM, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(aipt_pkg::CMD_XFORM, 2'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
		write_lift(32'h7FFF_FFFF);
		send(aipt_pkg::CMD_XFORM, 2'd0, ONE, ONE, 32'h7FFF_0000);
		write_lift(32'h8000_0000);
		send(aipt_pkg::CMD_XFORM, 2'd0, ONE, ONE, 32'h8000_0000);
		// A zero row makes the matrix singular; the old inverse stays unused.
		send(aipt_pkg::CMD_LOAD, 2'd1, 0, 0, 0);
		send(aipt_pkg::CMD_LOAD, 2'd3, ONE, ONE, ONE);
		send(aipt_pkg::CMD_XFORM, 2'd0, ONE, 2 * ONE, 3 * ONE);
		// Tiny scale gives a huge, saturating inverse.
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 5};
		load_matrix(m);
		send(aipt_pkg::CMD_XFORM, 2'd0, ONE, -ONE, 7);
		// Huge scale gives an inverse that truncates to near zero.
		m = '{32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0};
		load_matrix(m);
		send(aipt_pkg::CMD_XFORM, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, ONE);
		write_lift(0);

		n = 0;
		while (n < 480) begin
			if (n > 400) calm = 1'b1;
			if (n % 120 == 60) write_lift($urandom());
			if ($urandom_range(0, 9) == 0) begin
				// Stray row reload or a lone inversion on the current rows.
				send(aipt_pkg::CMD_LOAD, 2'($urandom_range(0, 3)), pick_value(),
					pick_value(), pick_value());
				n++;
			end else begin
				if ($urandom_range(0, 5) == 0) begin
					// Repeated row leaves a rank-deficient matrix.
					m[0] = pick_value(); m[1] = pick_value(); m[2] = pick_value();
					m[3] = m[0]; m[4] = m[1]; m[5] = m[2];
					for (int j = 6; j < 12; j++) m[j] = pick_value();
				end else begin
					for (int j = 0; j < 12; j++) m[j] = pick_value();
				end
				load_matrix(m);
				n += 4;
				points = $urandom_range(1, 10);
				for (int p = 0; p < points; p++) begin
					send(aipt_pkg::CMD_XFORM, 2'($urandom_range(0, 3)), pick_value(),
						pick_value(), pick_value());
					n++;
				end
			end
		end
		drain();
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("tb_affine_inverse_point_transform: PASS");
		end else begin
			$display("tb_affine_inverse_point_transform: FAIL");
		end
		$finish;
	end

endmodule

// File: affine_inverse_point_transform.f
design/aipt_pkg.sv
design/aipt_ram.sv
design/aipt_div.sv
design/affine_inverse_point_transform.sv
tb/sv/aipt_checker.sv
tb/sv/tb_affine_inverse_point_transform.sv
